FILE: design/cfb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfb_pkg
// shared types and constants of the command frame builder
// ----------------------------------------------------------------------------
package cfb_pkg;

    localparam int BYTE_W    = 8;
    localparam int FRAME_LEN = 9;
    localparam int NUM_SYNC  = 4;
    localparam int KIND_W    = 2;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // what a chain slot carries
    localparam logic [KIND_W-1:0] KIND_SYNC   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DATA   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CRC_HI = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CRC_LO = 2'd3;

    typedef struct packed {
        logic              vld;
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data;
    } slot_t;

    localparam slot_t SLOT_EMPTY = '{vld: 1'b0, kind: KIND_SYNC, data: '0};

endpackage

FILE: design/cfb_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfb_cell
// one byte slot of the frame shift chain
// ----------------------------------------------------------------------------
module cfb_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  logic           shift,
    input  cfb_pkg::slot_t load_slot,
    input  cfb_pkg::slot_t next_slot,
    output cfb_pkg::slot_t slot
);
    import cfb_pkg::*;

    slot_t slot_reg;
    slot_t slot_next;

    always_comb
    begin
        slot_next = slot_reg;
        if (load)
        begin
            slot_next = load_slot;
        end
        else if (shift)
        begin
            slot_next = next_slot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= SLOT_EMPTY;
        end
        else
        begin
            slot_reg <= slot_next;
        end
    end

    assign slot = slot_reg;

endmodule

FILE: design/cfb_crc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfb_crc
// crc-16 ccitt-false accumulator, one byte per step, msb first
// ----------------------------------------------------------------------------
module cfb_crc (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       absorb,
    input  logic [cfb_pkg::BYTE_W-1:0] data,
    output logic [15:0]                crc_cur,
    output logic [15:0]                crc_upd
);
    import cfb_pkg::*;

    logic [15:0] crc_reg;
    logic [15:0] crc_next;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [BYTE_W-1:0] d);
        logic [15:0] c;
        begin
            c = crc_in ^ {d, 8'h00};
            for (int k = 0; k < BYTE_W; k++)
            begin
                if (c[15])
                begin
                    c = {c[14:0], 1'b0} ^ CRC_POLY;
                end
                else
                begin
                    c = {c[14:0], 1'b0};
                end
            end
            crc_byte = c;
        end
    endfunction

    assign crc_upd = crc_byte(crc_reg, data);

    always_comb
    begin
        crc_next = crc_reg;
        if (start)
        begin
            crc_next = CRC_INIT;
        end
        else if (absorb)
        begin
            crc_next = crc_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= CRC_INIT;
        end
        else
        begin
            crc_reg <= crc_next;
        end
    end

    assign crc_cur = crc_reg;

endmodule

FILE: design/crc16_command_frame_builder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc16_command_frame_builder
// builds a nine-byte command frame: four sync bytes, size, command, special,
// crc-16 high and low byte
// ----------------------------------------------------------------------------
// the first frame byte is offered in the cycle after the request is taken
// one byte per cycle while m_axis_tready is high, through a nine-cell shift
// chain; the next request loads while the last byte is taken
// the crc is folded in one byte per shift as the data bytes leave the chain
// reset clears the chain and sets all sync bytes to zero
module crc16_command_frame_builder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // frame_size, command, special_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // frame_byte
    output logic        m_axis_tlast
);
    import cfb_pkg::*;

    logic [BYTE_W-1:0] sync_reg  [NUM_SYNC];
    logic [BYTE_W-1:0] sync_next [NUM_SYNC];

    slot_t       slot      [FRAME_LEN];
    slot_t       load_slot [FRAME_LEN];
    slot_t       next_slot [FRAME_LEN];
    logic        load;
    logic        shift;
    logic        absorb;
    logic [15:0] crc_cur;
    logic [15:0] crc_upd;

    // sync byte registers
    always_comb
    begin
        for (int i = 0; i < NUM_SYNC; i++)
        begin
            sync_next[i] = sync_reg[i];
        end
        if (cfg_we)
        begin
            sync_next[cfg_index] = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SYNC; i++)
            begin
                sync_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < NUM_SYNC; i++)
            begin
                sync_reg[i] <= sync_next[i];
            end
        end
    end

    assign m_axis_tvalid = slot[0].vld;
    assign m_axis_tdata  = slot[0].data;
    assign m_axis_tlast  = (slot[0].kind == KIND_CRC_LO);

    assign shift         = slot[0].vld && m_axis_tready;
    assign s_axis_tready = !slot[0].vld || (m_axis_tready && m_axis_tlast);
    assign load          = s_axis_tvalid && s_axis_tready;
    assign absorb        = shift && (slot[0].kind == KIND_DATA);

    // frame layout as loaded into the chain
    always_comb
    begin
        for (int i = 0; i < NUM_SYNC; i++)
        begin
            load_slot[i] = '{vld: 1'b1, kind: KIND_SYNC, data: sync_reg[i]};
        end
        load_slot[4] = '{vld: 1'b1, kind: KIND_DATA,   data: s_axis_tdata[7:0]};
        load_slot[5] = '{vld: 1'b1, kind: KIND_DATA,   data: s_axis_tdata[15:8]};
        load_slot[6] = '{vld: 1'b1, kind: KIND_DATA,   data: s_axis_tdata[23:16]};
        load_slot[7] = '{vld: 1'b1, kind: KIND_CRC_HI, data: '0};
        load_slot[8] = '{vld: 1'b1, kind: KIND_CRC_LO, data: '0};
    end

    // neighbor hand-off; crc bytes are filled in as they reach the head
    always_comb
    begin
        for (int i = 0; i < FRAME_LEN - 1; i++)
        begin
            next_slot[i] = slot[i+1];
        end
        next_slot[FRAME_LEN-1] = SLOT_EMPTY;
        if (slot[1].kind == KIND_CRC_HI)
        begin
            // head still holds the last data byte, so take the updated crc
            next_slot[0].data = crc_upd[15:8];
        end
        else if (slot[1].kind == KIND_CRC_LO)
        begin
            next_slot[0].data = crc_cur[7:0];
        end
    end

    genvar g;
    generate
        for (g = 0; g < FRAME_LEN; g++)
        begin : g_cell
            cfb_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .load      (load),
                .shift     (shift),
                .load_slot (load_slot[g]),
                .next_slot (next_slot[g]),
                .slot      (slot[g])
            );
        end
    endgenerate

    cfb_crc u_crc (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (load),
        .absorb  (absorb),
        .data    (slot[0].data),
        .crc_cur (crc_cur),
        .crc_upd (crc_upd)
    );

endmodule
